@@ rtl/core/hpt_pkg.sv @@
// ----------------------------------------------------------------------------
// hpt_pkg
// Shared types and constants for the homogeneous point transform pipeline.
// ----------------------------------------------------------------------------
package hpt_pkg;

  // exact row sum width: three 64-bit products plus a shifted translation
  localparam int SUM_W   = 66;
  // quotient bits kept by the divider, one pipeline stage per bit
  localparam int Q_W     = 32;
  localparam int N_PAIRS = 8;
  localparam int N_COEF  = 16;
  localparam int IDX_W   = 3;

  // identity matrix in Q16.16 after reset
  localparam logic [N_PAIRS-1:0][63:0] COEF_RESET = '{
    64'h0001_0000_0000_0000,  // pair 7
    64'h0000_0000_0000_0000,  // pair 6
    64'h0000_0000_0001_0000,  // pair 5
    64'h0000_0000_0000_0000,  // pair 4
    64'h0000_0000_0000_0000,  // pair 3
    64'h0001_0000_0000_0000,  // pair 2
    64'h0000_0000_0000_0000,  // pair 1
    64'h0000_0000_0001_0000   // pair 0
  };

  typedef struct packed {
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
  } in_t;

  typedef struct packed {
    logic signed [31:0] out_x;
    logic signed [31:0] out_y;
    logic signed [31:0] out_z;
    logic signed [31:0] out_w;
    logic               divided;
    logic               saturated;
  } out_t;

  // state carried through the divider stages
  typedef struct packed {
    logic                        valid;
    logic                        div;
    logic signed [SUM_W-1:0]     w;
    logic [SUM_W-1:0]            den;
    logic [2:0][SUM_W-1:0]       rem;
    logic [2:0][Q_W-1:0]         q;
    logic [2:0]                  neg;
    logic [2:0]                  ovf;
  } div_t;

endpackage

@@ rtl/core/hpt_mult.sv @@
// ----------------------------------------------------------------------------
// hpt_mult
// First stage: the twelve coordinate by matrix entry products.
// ----------------------------------------------------------------------------
module hpt_mult (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   en,
  input  logic                   in_take,
  input  hpt_pkg::in_t           in_data,
  input  logic [15:0][31:0]      coef,
  output logic                   prod_valid,
  output logic [2:0][3:0][63:0]  prod
);

  logic [2:0][31:0] pos;

  assign pos[0] = in_data.pos_x;
  assign pos[1] = in_data.pos_y;
  assign pos[2] = in_data.pos_z;

  // valid travels with the products
  always_ff @(posedge clk) begin
    if (rst) begin
      prod_valid <= 1'b0;
    end else if (en) begin
      prod_valid <= in_take;
    end
  end

  // one 32x32 signed multiplier per product
  always_ff @(posedge clk) begin
    if (en) begin
      for (int j = 0; j < 3; j++) begin
        for (int r = 0; r < 4; r++) begin
          prod[j][r] <= $signed(pos[j]) * $signed(coef[4*j+r]);
        end
      end
    end
  end

endmodule

@@ rtl/core/hpt_sum.sv @@
// ----------------------------------------------------------------------------
// hpt_sum
// Row sums, then w, magnitudes and quotient overflow check for the divider.
// ----------------------------------------------------------------------------
module hpt_sum #(
  parameter int FRAC_BITS = 16
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   en,
  input  logic                   prod_valid,
  input  logic [2:0][3:0][63:0]  prod,
  input  logic [15:0][31:0]      coef,
  output hpt_pkg::div_t          div_out
);

  localparam int SW  = hpt_pkg::SUM_W;
  localparam int QW  = hpt_pkg::Q_W;
  localparam int XW  = SW + QW;

  logic                       sum_valid;
  logic [3:0][SW-1:0]         sum;
  logic [3:0][SW-1:0]         sum_next;
  logic signed [SW-1:0]       w_val;
  logic [SW-1:0]              w_mag;
  logic                       w_neg;
  logic                       w_nz;
  logic [2:0][SW-1:0]         s_mag;
  logic [2:0]                 s_neg;
  logic [XW-1:0]              den_x;
  hpt_pkg::div_t              div_next;

  // exact row sums in Q34.32
  always_comb begin
    for (int r = 0; r < 4; r++) begin
      sum_next[r] = SW'($signed(prod[0][r])) + SW'($signed(prod[1][r]))
                  + SW'($signed(prod[2][r]))
                  + (SW'($signed(coef[12+r])) <<< FRAC_BITS);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sum_valid <= 1'b0;
    end else if (en) begin
      sum_valid <= prod_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sum <= sum_next;
    end
  end

  // w and its magnitude
  assign w_val = $signed(sum[3]) >>> FRAC_BITS;
  assign w_neg = w_val[SW-1];
  assign w_nz  = |w_val;
  assign w_mag = w_neg ? SW'(-w_val) : SW'(w_val);
  assign den_x = {w_mag, {QW{1'b0}}};

  // divider setup; without a divide the raw sum rides through unchanged
  always_comb begin
    div_next       = '0;
    div_next.valid = sum_valid;
    div_next.div   = w_nz;
    div_next.w     = w_val;
    div_next.den   = w_nz ? w_mag : '0;
    for (int r = 0; r < 3; r++) begin
      s_neg[r] = sum[r][SW-1];
      s_mag[r] = s_neg[r] ? SW'(-$signed(sum[r])) : sum[r];
      div_next.rem[r] = w_nz ? s_mag[r] : sum[r];
      div_next.neg[r] = s_neg[r] ^ w_neg;
      div_next.ovf[r] = w_nz && (XW'(s_mag[r]) >= den_x);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      div_out.valid <= 1'b0;
    end else if (en) begin
      div_out <= div_next;
    end
  end

endmodule

@@ rtl/core/hpt_div_step.sv @@
// ----------------------------------------------------------------------------
// hpt_div_step
// One restoring division stage: resolves one quotient bit in all three lanes.
// ----------------------------------------------------------------------------
module hpt_div_step #(
  parameter int BIT = 0
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           en,
  input  hpt_pkg::div_t  div_in,
  output hpt_pkg::div_t  div_out
);

  localparam int SW = hpt_pkg::SUM_W;
  localparam int XW = hpt_pkg::SUM_W + hpt_pkg::Q_W;

  logic [XW-1:0]  den_x;
  logic [2:0][XW-1:0] rem_x;
  logic [2:0][XW-1:0] diff;
  logic [2:0]     take;
  hpt_pkg::div_t  div_next;

  assign den_x = XW'(div_in.den) << BIT;

  // compare and subtract the shifted divisor
  always_comb begin
    div_next = div_in;
    for (int r = 0; r < 3; r++) begin
      rem_x[r] = XW'(div_in.rem[r]);
      diff[r]  = rem_x[r] - den_x;
      take[r]  = rem_x[r] >= den_x;
      if (take[r]) begin
        div_next.rem[r] = diff[r][SW-1:0];
      end
      div_next.q[r][BIT] = take[r];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      div_out.valid <= 1'b0;
    end else if (en) begin
      div_out <= div_next;
    end
  end

endmodule

@@ rtl/core/hpt_out.sv @@
// ----------------------------------------------------------------------------
// hpt_out
// Sign fix-up and saturation, then output register with a skid stage.
// ----------------------------------------------------------------------------
module hpt_out #(
  parameter int FRAC_BITS = 16
) (
  input  logic           clk,
  input  logic           rst,
  input  hpt_pkg::div_t  div_in,
  output logic           en,
  output logic           out_valid,
  input  logic           out_stall,
  output hpt_pkg::out_t  out_data,
  output logic           skid_valid
);

  localparam int SW = hpt_pkg::SUM_W;
  localparam int QW = hpt_pkg::Q_W;

  localparam logic [31:0] MAX32 = 32'h7FFF_FFFF;
  localparam logic [31:0] MIN32 = 32'h8000_0000;

  logic [2:0][31:0]     lane;
  logic [2:0]           lane_sat;
  logic signed [SW-1:0] shifted;
  logic [31:0]          w_res;
  logic                 w_sat;
  hpt_pkg::out_t        res;
  hpt_pkg::out_t        skid;

  // clamp a wide signed value to 32 bits
  function automatic logic [32:0] clamp(input logic [SW-1:0] v);
    logic ok;
    ok = (&v[SW-1:31]) | ~(|v[SW-1:31]);
    if (ok) begin
      clamp = {1'b0, v[31:0]};
    end else if (v[SW-1]) begin
      clamp = {1'b1, MIN32};
    end else begin
      clamp = {1'b1, MAX32};
    end
  endfunction

  // per lane result: signed quotient or shifted sum
  always_comb begin
    for (int r = 0; r < 3; r++) begin
      shifted = $signed(div_in.rem[r]) >>> FRAC_BITS;
      if (!div_in.div) begin
        {lane_sat[r], lane[r]} = clamp(shifted);
      end else if (div_in.ovf[r]) begin
        lane_sat[r] = 1'b1;
        lane[r]     = div_in.neg[r] ? MIN32 : MAX32;
      end else if (div_in.neg[r]) begin
        lane_sat[r] = div_in.q[r] > MIN32;
        lane[r]     = lane_sat[r] ? MIN32 : 32'(-div_in.q[r]);
      end else begin
        lane_sat[r] = div_in.q[r][QW-1];
        lane[r]     = lane_sat[r] ? MAX32 : div_in.q[r];
      end
    end
    {w_sat, w_res} = clamp(div_in.w);
    res.out_x     = lane[0];
    res.out_y     = lane[1];
    res.out_z     = lane[2];
    res.out_w     = w_res;
    res.divided   = div_in.div;
    res.saturated = (|lane_sat) | w_sat;
  end

  // pipeline moves while the skid stage is free
  assign en = !skid_valid;

  // output register and skid stage
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (out_valid && out_stall) begin
      if (en && div_in.valid) begin
        skid       <= res;
        skid_valid <= 1'b1;
      end
    end else if (skid_valid) begin
      out_data   <= skid;
      out_valid  <= 1'b1;
      skid_valid <= 1'b0;
    end else begin
      out_data  <= res;
      out_valid <= div_in.valid;
    end
  end

endmodule

@@ rtl/core/homogeneous_point_transform.sv @@
// ----------------------------------------------------------------------------
// homogeneous_point_transform
// 4x4 matrix transform of a Q16.16 point with perspective divide by w.
// ----------------------------------------------------------------------------
// Stages from an accepted transaction to out_valid: multiply, row sum, divider
// setup, 32 quotient-bit stages, output register.
// Throughput: one transaction per cycle while in_stall is low; the 32-stage
// restoring divider is fully pipelined; the skid keeps one stalled result.
// Reset: synchronous; clears all valid bits and loads the identity matrix.
module homogeneous_point_transform #(
  parameter int FRAC_BITS = 16
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  hpt_pkg::in_t                in_data,
  output logic                        out_valid,
  input  logic                        out_stall,
  output hpt_pkg::out_t               out_data,
  input  logic                        cfg_we,
  input  logic [hpt_pkg::IDX_W-1:0]   cfg_index,
  input  logic [63:0]                 cfg_data
);

  localparam int QW = hpt_pkg::Q_W;

  logic [hpt_pkg::N_PAIRS-1:0][63:0] coef_pair;
  logic [15:0][31:0]                 coef;
  logic                              en;
  logic                              skid_valid;
  logic                              prod_valid;
  logic [2:0][3:0][63:0]             prod;
  hpt_pkg::div_t                     div_chain [QW+1];

  // matrix registers
  always_ff @(posedge clk) begin
    if (rst) begin
      coef_pair <= hpt_pkg::COEF_RESET;
    end else if (cfg_we) begin
      coef_pair[cfg_index] <= cfg_data;
    end
  end

  // split register pairs into matrix entries
  for (genvar e = 0; e < hpt_pkg::N_COEF; e++) begin : g_coef
    assign coef[e] = coef_pair[e/2][(e%2)*32 +: 32];
  end

  assign in_stall = !en;

  hpt_mult u_mult (
    .clk        (clk),
    .rst        (rst),
    .en         (en),
    .in_take    (in_valid),
    .in_data    (in_data),
    .coef       (coef),
    .prod_valid (prod_valid),
    .prod       (prod)
  );

  hpt_sum #(.FRAC_BITS(FRAC_BITS)) u_sum (
    .clk        (clk),
    .rst        (rst),
    .en         (en),
    .prod_valid (prod_valid),
    .prod       (prod),
    .coef       (coef),
    .div_out    (div_chain[0])
  );

  // quotient bits from most to least significant
  for (genvar k = 0; k < QW; k++) begin : g_div
    hpt_div_step #(.BIT(QW-1-k)) u_step (
      .clk     (clk),
      .rst     (rst),
      .en      (en),
      .div_in  (div_chain[k]),
      .div_out (div_chain[k+1])
    );
  end

  hpt_out #(.FRAC_BITS(FRAC_BITS)) u_out (
    .clk        (clk),
    .rst        (rst),
    .div_in     (div_chain[QW]),
    .en         (en),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_data   (out_data),
    .skid_valid (skid_valid)
  );

  // skid stage only fills behind a held output
  a_skid_behind_out: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> out_valid)
    else $error("skid stage full without output");

  // no divide means w was zero
  a_nodiv_w_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_data.divided |-> out_data.out_w == 32'd0)
    else $error("undivided result with nonzero w");

  // divide means w was nonzero
  a_div_w_nonzero: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.divided |-> out_data.out_w != 32'd0)
    else $error("divided result with zero w");

endmodule
